// File: sv/amhs_pkg.sv
// ----------------------------------------------------------------------------
// amhs_pkg: shared types and constants of the axis homing sequencer
// Holds the beat layouts, register indexes, fault codes, event bit positions,
// timing constants and the table of allowed state changes.
// ----------------------------------------------------------------------------
package amhs_pkg;

  localparam int unsigned StateW = 3;
  localparam int unsigned NumStates = 8;
  localparam int unsigned EventW = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CFG_AXIS_ENABLED = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MARGIN_COUNTS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STOP_TIMEOUT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HUNT_ALLOWED = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOMING_SETTLE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HOME_SLOW_PROF = 3'd5;

  // Fault codes
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_FAST_TIMEOUT = 2'd1;
  localparam logic [1:0] FAULT_FINE_TIMEOUT = 2'd2;
  localparam logic [1:0] FAULT_STOP_TIMEOUT = 2'd3;

  // Event bit positions
  localparam int unsigned EV_CHANGE = 0;
  localparam int unsigned EV_IDLE = 1;
  localparam int unsigned EV_DONE = 2;
  localparam int unsigned EV_START = 3;
  localparam int unsigned EV_STOPPED = 4;
  localparam int unsigned EV_ERROR = 5;
  localparam int unsigned EV_HSTART = 6;
  localparam int unsigned EV_HCLEAR = 7;
  localparam int unsigned EV_HDONE = 8;

  // Timing constants in milliseconds
  localparam logic [31:0] HOME_TIMEOUT_MS = 32'd45000;
  localparam logic [31:0] BACKOFF_WAIT_MS = 32'd1000;
  localparam logic [31:0] HUNT_SETTLE_MS = 32'd600;

  // Row per source state, bit per destination state
  localparam logic [NumStates-1:0] ALLOWED [NumStates] = '{
    8'h1E,  // idle: executing, stopping, error, home fast
    8'h0D,  // executing: idle, stopping, error
    8'h09,  // stopping: idle, error
    8'h01,  // error: idle
    8'h28,  // home fast: backoff, error
    8'h48,  // backoff: fine, error
    8'h88,  // fine: settle, error
    8'h09   // settle: idle, error
  };

  typedef struct packed {
    logic               command;
    logic [StateW-1:0]  requested_state;
    logic [31:0]        now_ms;
    logic signed [31:0] position;
    logic signed [31:0] target;
    logic               limit_switch;
  } in_beat_t;

  typedef struct packed {
    logic [StateW-1:0]  state_now;
    logic               accepted;
    logic [EventW-1:0]  event_flags;
    logic               stop_all;
    logic               drive_axis;
    logic               drive_dir;
    logic [3:0]         profile_write;
    logic               zero_encoder;
    logic [1:0]         fault_code;
    logic signed [31:0] trigger_position;
    logic signed [31:0] stop_position;
  } res_beat_t;

endpackage

// File: sv/amhs_if.sv
// ----------------------------------------------------------------------------
// amhs_if: channel interfaces of the axis homing sequencer
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface amhs_in_if;
  import amhs_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface amhs_out_if;
  import amhs_pkg::*;
  logic      valid;
  logic      ready;
  res_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface amhs_cfg_if;
  import amhs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/axis_motion_homing_sequencer_top.sv
// ----------------------------------------------------------------------------
// axis_motion_homing_sequencer_top: single-axis motion and homing sequencer
// Guarded state table, target detection, hunting, stop timeout and a
// four-step homing sequence, one result beat per input beat.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock unless the result side stalls, and
// it returns exactly one result beat for each input beat it takes: the
// beat is held in an input register, the state handler then runs as one short
// combinational step (a 33-bit distance against the margin, a few 32-bit
// compares and the transition table lookup) that updates the axis state and
// loads the result register in the same edge. The next beat is evaluated
// against the updated state, so the sustained rate is one beat per cycle
// while the result side is not stalled. Back-pressure on the result channel
// stalls the result register first and the input register behind it; the
// input channel stays ready while a stage is free. Configuration writes take
// effect at once and are meant to be issued only while no beat is in flight.
// ----------------------------------------------------------------------------
module axis_motion_homing_sequencer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  amhs_in_if.sink           item_i,
  amhs_out_if.source        result_o,
  amhs_cfg_if.sink          cfg_i
);
  import amhs_pkg::*;

  typedef enum logic [StateW-1:0] {
    ST_IDLE   = 3'd0,
    ST_EXEC   = 3'd1,
    ST_STOP   = 3'd2,
    ST_ERR    = 3'd3,
    ST_FAST   = 3'd4,
    ST_BACK   = 3'd5,
    ST_FINE   = 3'd6,
    ST_SETTLE = 3'd7
  } state_e;

  // Configuration registers
  logic        enabled_q;
  logic [15:0] margin_q;
  logic [31:0] stop_tmo_q;
  logic        hunt_q;
  logic [15:0] settle_q;
  logic [2:0]  home_prof_q;

  // Axis state
  state_e      state_q, state_d;
  logic [31:0] entry_time_q, entry_time_d;
  logic signed [31:0] origin_pos_q, origin_pos_d;
  logic signed [31:0] stop_latch_q, stop_latch_d;
  logic signed [31:0] trig_latch_q, trig_latch_d;

  // Pipeline registers
  logic      in_valid_q;
  in_beat_t  in_beat_q;
  logic      out_valid_q;
  res_beat_t out_beat_q, out_beat_d;

  logic advance;
  logic commit;

  // Result stage frees up when empty or taken; input stage follows it
  assign advance = !out_valid_q || result_o.ready;
  assign commit = in_valid_q && advance;
  assign item_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign result_o.valid = out_valid_q;
  assign result_o.data = out_beat_q;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      margin_q <= 16'd1;
      stop_tmo_q <= 32'd5000;
      hunt_q <= 1'b1;
      settle_q <= 16'd500;
      home_prof_q <= 3'd0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_AXIS_ENABLED:   enabled_q <= cfg_i.data[0];
        CFG_MARGIN_COUNTS:  margin_q <= cfg_i.data[15:0];
        CFG_STOP_TIMEOUT:   stop_tmo_q <= cfg_i.data[31:0];
        CFG_HUNT_ALLOWED:   hunt_q <= cfg_i.data[0];
        CFG_HOMING_SETTLE:  settle_q <= cfg_i.data[15:0];
        CFG_HOME_SLOW_PROF: home_prof_q <= cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State handler
  // --------------------------------------------------------------------------
  always_comb begin
    logic [15:0]        margin_eff;
    logic signed [32:0] diff;
    logic [32:0]        abs_diff;
    logic               on_target;
    logic               overshoot;
    logic [31:0]        elapsed;
    logic [NumStates-1:0] row;
    logic               go;
    state_e             to;
    logic               stop_all;
    logic               drive;
    logic               dir;
    logic [3:0]         prof;
    logic [3:0]         home_prof_wr;
    logic               zero;
    logic [1:0]         fault;
    logic               hdone;
    logic               trig_set;
    logic [EventW-1:0]  ev;

    margin_eff = (margin_q == 16'd0) ? 16'd1 : margin_q;
    diff = {in_beat_q.position[31], in_beat_q.position}
         - {in_beat_q.target[31], in_beat_q.target};
    abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
    on_target = abs_diff <= {17'd0, margin_eff};
    overshoot = (origin_pos_q < in_beat_q.target && in_beat_q.position >= in_beat_q.target)
             || (origin_pos_q > in_beat_q.target && in_beat_q.position <= in_beat_q.target);
    elapsed = in_beat_q.now_ms - entry_time_q;
    row = ALLOWED[state_q];
    home_prof_wr = {1'b0, home_prof_q} + 4'd1;

    go = 1'b0;
    to = state_q;
    stop_all = 1'b0;
    drive = 1'b0;
    dir = 1'b0;
    prof = 4'd0;
    zero = 1'b0;
    fault = FAULT_NONE;
    hdone = 1'b0;
    trig_set = 1'b0;

    if (in_beat_q.command) begin
      // Request: same state and error are always admitted
      if (in_beat_q.requested_state == state_q || in_beat_q.requested_state == ST_ERR
          || row[in_beat_q.requested_state]) begin
        go = 1'b1;
        to = state_e'(in_beat_q.requested_state);
      end
    end else if (enabled_q) begin
      case (state_q)
        ST_EXEC: begin
          if (on_target || overshoot) begin
            stop_all = 1'b1;
            go = 1'b1;
            to = ST_STOP;
          end
        end
        ST_STOP: begin
          if (on_target) begin
            go = 1'b1;
            to = ST_IDLE;
          end else if (hunt_q && elapsed > HUNT_SETTLE_MS) begin
            // Hunt back toward the target on profile 0
            prof = 4'd1;
            drive = 1'b1;
            dir = in_beat_q.target > in_beat_q.position;
            go = 1'b1;
            to = ST_EXEC;
          end else if (elapsed > stop_tmo_q) begin
            fault = FAULT_STOP_TIMEOUT;
            go = 1'b1;
            to = ST_IDLE;
          end
        end
        ST_FAST: begin
          if (elapsed > HOME_TIMEOUT_MS) begin
            fault = FAULT_FAST_TIMEOUT;
            go = 1'b1;
            to = ST_ERR;
          end else if (in_beat_q.limit_switch) begin
            stop_all = 1'b1;
            prof = home_prof_wr;
            drive = 1'b1;
            dir = 1'b1;
            go = 1'b1;
            to = ST_BACK;
          end
        end
        ST_BACK: begin
          if (!in_beat_q.limit_switch && elapsed > BACKOFF_WAIT_MS) begin
            stop_all = 1'b1;
            prof = home_prof_wr;
            drive = 1'b1;
            go = 1'b1;
            to = ST_FINE;
          end
        end
        ST_FINE: begin
          if (elapsed > HOME_TIMEOUT_MS) begin
            fault = FAULT_FINE_TIMEOUT;
            go = 1'b1;
            to = ST_ERR;
          end else if (in_beat_q.limit_switch) begin
            trig_set = 1'b1;
            go = 1'b1;
            to = ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          if (elapsed > {16'd0, settle_q}) begin
            zero = 1'b1;
            hdone = 1'b1;
            go = 1'b1;
            to = ST_IDLE;
          end
        end
        default: ;
      endcase
    end

    // Entry actions of the new state
    if (go && to == ST_ERR) begin
      stop_all = 1'b1;
    end

    ev = '0;
    ev[EV_CHANGE] = go;
    ev[EV_IDLE] = go && to == ST_IDLE;
    ev[EV_DONE] = go && to == ST_IDLE && (state_q inside {ST_EXEC, ST_STOP});
    ev[EV_START] = go && to == ST_EXEC;
    ev[EV_STOPPED] = go && to == ST_STOP;
    ev[EV_ERROR] = go && to == ST_ERR;
    ev[EV_HSTART] = go && to == ST_FAST;
    ev[EV_HCLEAR] = go && to == ST_SETTLE;
    ev[EV_HDONE] = hdone;

    state_d = state_q;
    entry_time_d = entry_time_q;
    origin_pos_d = origin_pos_q;
    stop_latch_d = stop_latch_q;
    trig_latch_d = trig_latch_q;
    if (go) begin
      state_d = to;
      entry_time_d = in_beat_q.now_ms;
      if (to == ST_EXEC) begin
        origin_pos_d = in_beat_q.position;
      end
      if (to == ST_STOP) begin
        stop_latch_d = in_beat_q.position;
      end
    end
    if (trig_set) begin
      trig_latch_d = in_beat_q.position;
    end

    out_beat_d.state_now = state_d;
    out_beat_d.accepted = go;
    out_beat_d.event_flags = ev;
    out_beat_d.stop_all = stop_all;
    out_beat_d.drive_axis = drive;
    out_beat_d.drive_dir = dir;
    out_beat_d.profile_write = prof;
    out_beat_d.zero_encoder = zero;
    out_beat_d.fault_code = fault;
    out_beat_d.trigger_position = trig_latch_d;
    out_beat_d.stop_position = stop_latch_d;
  end

  // --------------------------------------------------------------------------
  // Control registers: pipeline valids and axis state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= ST_IDLE;
      entry_time_q <= '0;
      origin_pos_q <= '0;
      stop_latch_q <= '0;
      trig_latch_q <= '0;
    end else begin
      if (item_i.ready) begin
        in_valid_q <= item_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      // Advance the axis state only when the beat moves into the result stage
      if (commit) begin
        state_q <= state_d;
        entry_time_q <= entry_time_d;
        origin_pos_q <= origin_pos_d;
        stop_latch_q <= stop_latch_d;
        trig_latch_q <= trig_latch_d;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_beat_q <= item_i.data;
    end
    if (commit) begin
      out_beat_q <= out_beat_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(state_q))
    else $error("axis state moved without a committed beat");

  a_event_matches_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_beat_q.event_flags[EV_CHANGE] == out_beat_q.accepted)
    else $error("change event and accepted disagree");

  a_fault_needs_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_beat_q.fault_code != FAULT_NONE |-> out_beat_q.accepted)
    else $error("fault reported without a state change");

  a_zero_ends_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_beat_q.zero_encoder
      |-> out_beat_q.state_now == ST_IDLE && out_beat_q.event_flags[EV_HDONE])
    else $error("encoder zeroed outside homing completion");

  a_commit_fills_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && state_q == out_beat_q.state_now)
    else $error("committed beat lost or state mismatch in result");

endmodule

// File: verif/amhs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amhs_checker: result checker for the axis homing sequencer
// Watches the item, result and register channels, keeps its own copy of the
// axis state machine and compares every result beat with its prediction.
// ----------------------------------------------------------------------------
package amhs_tb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STOP,
    ST_ERROR,
    ST_HOME_FAST,
    ST_HOME_BACK,
    ST_HOME_FINE,
    ST_HOME_SETTLE
  } axis_state_e;

  typedef enum logic {
    CMD_TICK,
    CMD_REQUEST
  } axis_cmd_e;

endpackage

module amhs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  amhs_in_if          item_mon,
  amhs_out_if         res_mon,
  amhs_cfg_if         cfg_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  import amhs_pkg::*;
  import amhs_tb_pkg::*;

  // Register copies
  logic        axis_en;
  logic [15:0] margin;
  logic [31:0] stop_tmo;
  logic        hunt_en;
  logic [15:0] settle_ms;
  logic [2:0]  home_prof;

  // Axis state copy
  axis_state_e        cur_state;
  logic [31:0]        entry_ms;
  logic signed [31:0] origin_pos;
  logic signed [31:0] stop_pos;
  logic signed [31:0] trig_pos;

  res_beat_t step_res;
  res_beat_t awaited_results [$];
  string     bad_fields;
  res_beat_t want;

  function automatic void enter_state(axis_state_e to, logic [31:0] now,
                                      logic [31:0] pos);
    axis_state_e prev;
    prev = cur_state;
    cur_state = to;
    entry_ms = now;
    step_res.accepted = 1'b1;
    step_res.event_flags[EV_CHANGE] = 1'b1;
    case (to)
      ST_IDLE: begin
        step_res.event_flags[EV_IDLE] = 1'b1;
        if (prev == ST_EXEC || prev == ST_STOP) step_res.event_flags[EV_DONE] = 1'b1;
      end
      ST_EXEC: begin
        origin_pos = pos;
        step_res.event_flags[EV_START] = 1'b1;
      end
      ST_STOP: begin
        stop_pos = pos;
        step_res.event_flags[EV_STOPPED] = 1'b1;
      end
      ST_ERROR: begin
        step_res.stop_all = 1'b1;
        step_res.event_flags[EV_ERROR] = 1'b1;
      end
      ST_HOME_FAST: step_res.event_flags[EV_HSTART] = 1'b1;
      ST_HOME_SETTLE: step_res.event_flags[EV_HCLEAR] = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic res_beat_t step_axis(in_beat_t b);
    logic [31:0] elapsed;
    longint      pos, tgt, sp, gap_abs, marg;
    axis_state_e req;
    step_res = '0;
    elapsed = b.now_ms - entry_ms;
    pos = $signed(b.position);
    tgt = $signed(b.target);
    sp = $signed(origin_pos);
    marg = (margin == 16'd0) ? 64'sd1 : longint'({48'd0, margin});
    gap_abs = (pos >= tgt) ? pos - tgt : tgt - pos;
    req = axis_state_e'(b.requested_state);

    if (b.command == CMD_REQUEST) begin
      if (req == cur_state || req == ST_ERROR || ALLOWED[cur_state][req])
        enter_state(req, b.now_ms, b.position);
    end else if (axis_en) begin
      case (cur_state)
        ST_EXEC: begin
          if (gap_abs <= marg || (sp < tgt && pos >= tgt) || (sp > tgt && pos <= tgt)) begin
            step_res.stop_all = 1'b1;
            enter_state(ST_STOP, b.now_ms, b.position);
          end
        end
        ST_STOP: begin
          if (gap_abs <= marg) begin
            enter_state(ST_IDLE, b.now_ms, b.position);
          end else if (hunt_en && elapsed > HUNT_SETTLE_MS) begin
            step_res.profile_write = 4'd1;
            step_res.drive_axis = 1'b1;
            step_res.drive_dir = (tgt > pos);
            enter_state(ST_EXEC, b.now_ms, b.position);
          end else if (elapsed > stop_tmo) begin
            step_res.fault_code = FAULT_STOP_TIMEOUT;
            enter_state(ST_IDLE, b.now_ms, b.position);
          end
        end
        ST_HOME_FAST: begin
          if (elapsed > HOME_TIMEOUT_MS) begin
            step_res.fault_code = FAULT_FAST_TIMEOUT;
            enter_state(ST_ERROR, b.now_ms, b.position);
          end else if (b.limit_switch) begin
            step_res.stop_all = 1'b1;
            step_res.profile_write = {1'b0, home_prof} + 4'd1;
            step_res.drive_axis = 1'b1;
            step_res.drive_dir = 1'b1;
            enter_state(ST_HOME_BACK, b.now_ms, b.position);
          end
        end
        ST_HOME_BACK: begin
          if (!b.limit_switch && elapsed > BACKOFF_WAIT_MS) begin
            step_res.stop_all = 1'b1;
            step_res.profile_write = {1'b0, home_prof} + 4'd1;
            step_res.drive_axis = 1'b1;
            step_res.drive_dir = 1'b0;
            enter_state(ST_HOME_FINE, b.now_ms, b.position);
          end
        end
        ST_HOME_FINE: begin
          if (elapsed > HOME_TIMEOUT_MS) begin
            step_res.fault_code = FAULT_FINE_TIMEOUT;
            enter_state(ST_ERROR, b.now_ms, b.position);
          end else if (b.limit_switch) begin
            trig_pos = b.position;
            enter_state(ST_HOME_SETTLE, b.now_ms, b.position);
          end
        end
        ST_HOME_SETTLE: begin
          if (elapsed > {16'd0, settle_ms}) begin
            step_res.zero_encoder = 1'b1;
            step_res.event_flags[EV_HDONE] = 1'b1;
            enter_state(ST_IDLE, b.now_ms, b.position);
          end
        end
        default: ;
      endcase
    end

    step_res.state_now = cur_state;
    step_res.trigger_position = trig_pos;
    step_res.stop_position = stop_pos;
    return step_res;
  endfunction

  function automatic string fmt_res(res_beat_t r);
    return $sformatf({"st=%0d acc=%0b ev=%03h stop_all=%0b drive=%0b dir=%0b prof=%0d",
                      " zero=%0b fault=%0d trig=%0d stop_pos=%0d"},
                     r.state_now, r.accepted, r.event_flags, r.stop_all, r.drive_axis,
                     r.drive_dir, r.profile_write, r.zero_encoder, r.fault_code,
                     r.trigger_position, r.stop_position);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_en = 1'b1;
      margin = 16'd1;
      stop_tmo = 32'd5000;
      hunt_en = 1'b1;
      settle_ms = 16'd500;
      home_prof = 3'd0;
      cur_state = ST_IDLE;
      entry_ms = '0;
      origin_pos = '0;
      stop_pos = '0;
      trig_pos = '0;
      awaited_results.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.index)
          CFG_AXIS_ENABLED: axis_en = cfg_mon.data[0];
          CFG_MARGIN_COUNTS: margin = cfg_mon.data[15:0];
          CFG_STOP_TIMEOUT: stop_tmo = cfg_mon.data;
          CFG_HUNT_ALLOWED: hunt_en = cfg_mon.data[0];
          CFG_HOMING_SETTLE: settle_ms = cfg_mon.data[15:0];
          CFG_HOME_SLOW_PROF: home_prof = cfg_mon.data[2:0];
          default: ;
        endcase
      end

      if (item_mon.valid === 1'b1 && item_mon.ready === 1'b1)
        awaited_results.push_back(step_axis(item_mon.data));

      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        if (awaited_results.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("[%0t] result beat with nothing awaited: %s", $time,
                     fmt_res(res_mon.data));
        end else begin
          want = awaited_results.pop_front();
          bad_fields = "";
          if (res_mon.data.state_now !== want.state_now)
            bad_fields = {bad_fields, " state_now"};
          if (res_mon.data.accepted !== want.accepted)
            bad_fields = {bad_fields, " accepted"};
          if (res_mon.data.event_flags !== want.event_flags)
            bad_fields = {bad_fields, " event_flags"};
          if (res_mon.data.stop_all !== want.stop_all)
            bad_fields = {bad_fields, " stop_all"};
          if (res_mon.data.drive_axis !== want.drive_axis)
            bad_fields = {bad_fields, " drive_axis"};
          if (res_mon.data.drive_dir !== want.drive_dir)
            bad_fields = {bad_fields, " drive_dir"};
          if (res_mon.data.profile_write !== want.profile_write)
            bad_fields = {bad_fields, " profile_write"};
          if (res_mon.data.zero_encoder !== want.zero_encoder)
            bad_fields = {bad_fields, " zero_encoder"};
          if (res_mon.data.fault_code !== want.fault_code)
            bad_fields = {bad_fields, " fault_code"};
          if (res_mon.data.trigger_position !== want.trigger_position)
            bad_fields = {bad_fields, " trigger_position"};
          if (res_mon.data.stop_position !== want.stop_position)
            bad_fields = {bad_fields, " stop_position"};
          if (bad_fields != "") begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10) begin
              $display("[%0t] result mismatch in%s", $time, bad_fields);
              $display("  expected %s", fmt_res(want));
              $display("  actual   %s", fmt_res(res_mon.data));
            end
          end
        end
      end

      pending_o = awaited_results.size();
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the axis homing sequencer
// Drives directed beats for the corner cases, then phases of random move and
// homing sequences under several register settings, with bursty input traffic
// and result back-pressure. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import amhs_pkg::*;
  import amhs_tb_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseItems = 110;
  localparam int unsigned DisabledPhaseItems = 50;

  // Receiver behavior, one mode per stretch of cycles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_CHOKED
  } rx_mode_e;

  logic        clk;
  logic        rst_n;
  int unsigned fail_cnt;
  int unsigned pending;

  // Stimulus bookkeeping
  logic [31:0] ms_now;
  int unsigned burst_left;
  int unsigned sent_cnt;
  int unsigned settle_shadow;

  amhs_in_if  item_if ();
  amhs_out_if res_if ();
  amhs_cfg_if cfg_if ();

  axis_motion_homing_sequencer_top dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  amhs_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_mon   (item_if),
    .res_mon    (res_if),
    .cfg_mon    (cfg_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run; the limit is many times the slowest legal run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: pick a stall mode, hold it for a random stretch, then move on.
  // The open mode gives the long stretches with no stall at all.
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    res_if.ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 60);
      end
      mode_left--;
      case (mode)
        RX_OPEN: res_if.ready <= 1'b1;
        RX_COIN: res_if.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: res_if.ready <= (mode_left % 4) != 0;
        default: res_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  function automatic in_beat_t mk_beat(axis_cmd_e cmd, axis_state_e req, logic [31:0] now,
                                       logic [31:0] pos, logic [31:0] tgt, logic lim);
    in_beat_t b;
    b.command = cmd;
    b.requested_state = req;
    b.now_ms = now;
    b.position = pos;
    b.target = tgt;
    b.limit_switch = lim;
    return b;
  endfunction

  // Random time step between ticks: mostly short, now and then at or beyond the homing timeout.
  function automatic logic [31:0] pace_ms();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 400);
    if (pick < 90) return $urandom_range(400, 1500);
    if (pick < 97) return $urandom_range(1500, 8000);
    return $urandom_range(45000, 60000);
  endfunction

  function automatic int pick_pos();
    return ($urandom_range(0, 4) == 0) ? int'($urandom)
                                       : int'($urandom_range(0, 20000)) - 10000;
  endfunction

  // Call on a falling edge. Open a random gap at the start of each burst, then
  // hold valid until the beat is taken. Valid stays high on return so that the
  // next beat of the burst follows back to back.
  task automatic push_item(input in_beat_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_if.valid <= 1'b1;
    item_if.data <= b;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    @(negedge clk);
    sent_cnt++;
  endtask

  task automatic send_request(axis_state_e st, logic [31:0] pos, logic [31:0] tgt);
    push_item(mk_beat(CMD_REQUEST, st, ms_now, pos, tgt, 1'($urandom_range(0, 1))));
  endtask

  task automatic send_tick(logic [31:0] pos, logic [31:0] tgt, logic lim);
    push_item(mk_beat(CMD_TICK, axis_state_e'($urandom_range(0, 7)), ms_now, pos, tgt, lim));
  endtask

  // Drop valid and hold off until every predicted result has come back, then
  // let the two-stage pipe run dry.
  task automatic drain_results();
    item_if.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(logic en, logic [15:0] marg, logic [31:0] tmo, logic hunt,
                               logic [15:0] settle, logic [2:0] prof);
    cfg_write(CFG_AXIS_ENABLED, {31'd0, en});
    cfg_write(CFG_MARGIN_COUNTS, {16'd0, marg});
    cfg_write(CFG_STOP_TIMEOUT, tmo);
    cfg_write(CFG_HUNT_ALLOWED, {31'd0, hunt});
    cfg_write(CFG_HOMING_SETTLE, {16'd0, settle});
    cfg_write(CFG_HOME_SLOW_PROF, {29'd0, prof});
    settle_shadow = settle;
  endtask

  // Point-to-point move: start, travel in a few legs (landing near, on or past
  // the target), then ticks around the target to exercise settle, hunting and
  // the stop timeout.
  task automatic run_move();
    int          p, t, jitter;
    longint      span;
    int unsigned legs;
    p = pick_pos();
    t = ($urandom_range(0, 9) == 0) ? int'($urandom)
                                    : p + int'($urandom_range(0, 6000)) - 3000;
    if ($urandom_range(0, 3) == 0) send_request(ST_ERROR, p, t);
    send_request(ST_IDLE, p, t);
    send_request(ST_EXEC, p, t);
    legs = $urandom_range(1, 6);
    span = longint'(t) - longint'(p);
    repeat (legs) begin
      jitter = int'($urandom_range(0, 40)) - 20;
      p = p + int'(span / longint'(legs)) + jitter;
      ms_now += pace_ms();
      send_tick(p, t, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 11) == 0) send_request(ST_STOP, p, t);
    end
    repeat ($urandom_range(1, 4)) begin
      ms_now += pace_ms();
      p = ($urandom_range(0, 3) == 0) ? pick_pos() : t + int'($urandom_range(0, 60)) - 30;
      send_tick(p, t, 1'($urandom_range(0, 1)));
    end
  endtask

  // Full homing pass: fast approach, switch hit, backoff, fine approach, settle.
  // Now and then let fast or fine approach run out of time instead.
  task automatic run_homing();
    int p, t;
    p = pick_pos();
    t = pick_pos();
    if ($urandom_range(0, 3) == 0) send_request(ST_ERROR, p, t);
    send_request(ST_IDLE, p, t);
    send_request(ST_HOME_FAST, p, t);
    repeat ($urandom_range(0, 2)) begin
      ms_now += $urandom_range(0, 3000);
      send_tick(p, t, 1'b0);
    end
    if ($urandom_range(0, 9) == 0) begin
      ms_now += 45001 + $urandom_range(0, 1000);
      send_tick(p, t, 1'($urandom_range(0, 1)));
      return;
    end
    ms_now += $urandom_range(0, 500);
    send_tick(p, t, 1'b1);
    // backoff: switch still pressed or too early, then a guaranteed release
    repeat ($urandom_range(0, 3)) begin
      ms_now += $urandom_range(0, 700);
      send_tick(p, t, 1'($urandom_range(0, 1)));
    end
    ms_now += 1001 + $urandom_range(0, 300);
    send_tick(p, t, 1'b0);
    repeat ($urandom_range(0, 2)) begin
      ms_now += $urandom_range(0, 3000);
      p = pick_pos();
      send_tick(p, t, 1'b0);
    end
    if ($urandom_range(0, 9) == 0) begin
      ms_now += 45001 + $urandom_range(0, 1000);
      send_tick(p, t, 1'($urandom_range(0, 1)));
      return;
    end
    ms_now += $urandom_range(0, 500);
    p = pick_pos();
    send_tick(p, t, 1'b1);
    repeat ($urandom_range(0, 2)) begin
      ms_now += $urandom_range(0, settle_shadow / 2);
      send_tick(pick_pos(), t, 1'($urandom_range(0, 1)));
    end
    ms_now += settle_shadow + 1 + $urandom_range(0, 20);
    send_tick(pick_pos(), t, 1'($urandom_range(0, 1)));
  endtask

  // Unstructured beats: any command, any state, any field values.
  task automatic run_noise();
    repeat ($urandom_range(1, 4)) begin
      ms_now += pace_ms();
      push_item(mk_beat(axis_cmd_e'($urandom_range(0, 1)), axis_state_e'($urandom_range(0, 7)),
                        ($urandom_range(0, 1) != 0) ? $urandom : ms_now,
                        $urandom, $urandom, 1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    int unsigned phase_goal;
    rst_n = 1'b0;
    item_if.valid = 1'b0;
    item_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    ms_now = '0;
    burst_left = 0;
    sent_cnt = 0;
    settle_shadow = 500;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- Directed beats, reset register values ----
    // Idle tick with every field at an extreme: nothing may move.
    ms_now = 32'hFFFF_FFFF;
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // Blocked request: backoff is not reachable from idle.
    ms_now = 32'd10;
    send_request(ST_HOME_BACK, 0, 0);
    // Same-state request still counts as a change.
    send_request(ST_IDLE, 0, 0);
    // Move from the most negative count toward the most positive one.
    ms_now = 32'd100;
    send_request(ST_EXEC, 32'h8000_0000, 32'h7FFF_FFFF);
    // Full-range distance must not wrap into the margin.
    ms_now = 32'd200;
    send_tick(32'h8000_0001, 32'h7FFF_FFFF, 1'b0);
    // Overshoot past the target ends the move.
    ms_now = 32'd300;
    send_tick(32'h7FFF_FFFF, 32'h7FFF_FFF0, 1'b0);
    // Exactly 600 ms out of margin: hold.
    ms_now = 32'd900;
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    // One ms later: hunt back toward the target, reverse direction.
    ms_now = 32'd901;
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    // One count off with the default margin: target reached.
    ms_now = 32'd950;
    send_tick(32'h8000_0001, 32'h8000_0000, 1'b0);
    // Still inside the margin while stopping: back to idle as completed.
    ms_now = 32'd960;
    send_tick(32'h8000_0001, 32'h8000_0000, 1'b1);
    // Error is always reachable; stopping is not reachable from error.
    send_request(ST_ERROR, 7, 7);
    send_request(ST_STOP, 7, 7);
    send_request(ST_IDLE, 7, 7);
    // Homing pass across the 32-bit time wrap.
    ms_now = 32'hFFFF_FC00;
    send_request(ST_HOME_FAST, 5, 5);
    ms_now += 100;
    send_tick(-40, 5, 1'b1);
    ms_now += 1000;
    send_tick(-40, 5, 1'b0);
    ms_now += 1;
    send_tick(-40, 5, 1'b0);
    ms_now += 200;
    send_tick(-123456, 5, 1'b1);
    ms_now += 500;
    send_tick(-123456, 5, 1'b0);
    ms_now += 1;
    send_tick(-123456, 5, 1'b0);
    // Fast approach times out even with the switch pressed.
    ms_now = 32'd5000;
    send_request(ST_HOME_FAST, 0, 0);
    ms_now += 45001;
    send_tick(0, 0, 1'b1);
    send_request(ST_IDLE, 0, 0);
    // Step to fine approach by request, then let it time out.
    send_request(ST_HOME_FAST, 0, 0);
    send_request(ST_HOME_BACK, 0, 0);
    send_request(ST_HOME_FINE, 0, 0);
    ms_now += 45001;
    send_tick(0, 0, 1'b1);

    // ---- Random phases, one register setting each ----
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph)
        0: apply_setting(1'b1, 16'd0, 32'd700, 1'b1, 16'd0, 3'd7);
        1: apply_setting(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 3'd0);
        2: apply_setting(1'b1, 16'd20, 32'd300, 1'b0, 16'd200, 3'd3);
        3: apply_setting(1'b0, 16'd5, 32'd1000, 1'b1, 16'd100, 3'd5);
        4: apply_setting(1'b1, 16'd3, 32'd0, 1'b1, 16'd700, 3'd6);
        default: apply_setting(1'b1, 16'($urandom_range(0, 200)), $urandom_range(0, 3000),
                               1'($urandom_range(0, 1)), 16'($urandom_range(0, 2000)),
                               3'($urandom_range(0, 7)));
      endcase
      ms_now = $urandom;
      phase_goal = sent_cnt + ((ph == 3) ? DisabledPhaseItems : PhaseItems);
      while (sent_cnt < phase_goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: run_move();
          4, 5, 6: run_homing();
          default: run_noise();
        endcase
        // Now and then pause the sender until everything has come back.
        if ($urandom_range(0, 19) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
